// ----- design/vr_pkg.sv -----
// ----------------------------------------------------------------------------
// vr_pkg: shared definitions for the 2D vector rotator
// Widths, fixed-point constants, the arctangent table and the structs that
// move between the pipeline cells.
// ----------------------------------------------------------------------------
package vr_pkg;

  localparam int CORDIC_STEPS = 20;
  // More than 32 micro-rotations behave like 32.
  localparam int VR_STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  localparam int CW         = 32;  // coordinate and angle port width
  localparam int MAG_W      = 46;  // |angle| in Q30
  localparam int MOD_STAGES = 13;  // binary digits of the quotient by 2*pi
  localparam int RW         = 35;  // signed reduced angle before folding
  localparam int ZW         = 34;  // signed residual angle in the rotation cells
  localparam int DW         = 51;  // signed coordinate datapath, Q16.32 plus headroom
  localparam int PW         = 66;  // gain product width
  localparam int SW         = 5;   // step index width

  localparam logic [MAG_W-1:0] TWO_PI_MAG = 46'h1921FB544;
  localparam logic signed [RW-1:0] TWO_PI_R  = 35'sh1921FB544;
  localparam logic signed [RW-1:0] PI_R      = 35'sh0C90FDAA2;
  localparam logic signed [RW-1:0] HALF_PI_R = 35'sh06487ED51;
  localparam logic signed [PW-1:0] GAIN_Q31  = 66'sh4DBA76D4;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
    32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
  };

  function automatic logic [31:0] vr_atan(input logic [SW-1:0] idx);
    return ATAN_Q30[idx];
  endfunction

  function automatic logic [MAG_W-1:0] vr_mod_sub(input int shift);
    return TWO_PI_MAG << shift;
  endfunction

  // Request moving through the angle reduction cells.
  typedef struct packed {
    logic                  valid;
    logic                  neg;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic [MAG_W-1:0]      mag;
  } vr_mod_t;

  // Request moving through the micro-rotation cells.
  typedef struct packed {
    logic                  valid;
    logic signed [DW-1:0]  x;
    logic signed [DW-1:0]  y;
    logic signed [ZW-1:0]  z;
  } vr_rot_t;

endpackage

// ----- design/vr_mod_cell.sv -----
// ----------------------------------------------------------------------------
// vr_mod_cell: one digit of the angle reduction
// Subtracts a fixed multiple of 2*pi from the angle magnitude when it fits.
// ----------------------------------------------------------------------------
module vr_mod_cell
  import vr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [MAG_W-1:0] sub_i,
  input  vr_mod_t          d_i,
  output vr_mod_t          q_o
);

  logic       valid_q;
  vr_mod_t    data_q;
  vr_mod_t    data_d;

  always_comb begin
    data_d = d_i;
    if (d_i.mag >= sub_i) begin
      data_d.mag = d_i.mag - sub_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    q_o       = data_q;
    q_o.valid = valid_q;
  end

endmodule

// ----- design/vr_rot_cell.sv -----
// ----------------------------------------------------------------------------
// vr_rot_cell: one CORDIC micro-rotation
// Rotates by +-atan(2^-step) depending on the sign of the residual angle.
// ----------------------------------------------------------------------------
module vr_rot_cell
  import vr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [SW-1:0] step_i,
  input  vr_rot_t       d_i,
  output vr_rot_t       q_o
);

  logic                 valid_q;
  vr_rot_t              data_q;
  vr_rot_t              data_d;
  logic signed [DW-1:0] x_s;
  logic signed [DW-1:0] y_s;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [ZW-1:0] z_s;
  logic signed [ZW-1:0] da;

  always_comb begin
    x_s = d_i.x;
    y_s = d_i.y;
    z_s = d_i.z;
    dx  = y_s >>> step_i;
    dy  = x_s >>> step_i;
    da  = ZW'(vr_atan(step_i));
    data_d = d_i;
    if (!z_s[ZW-1]) begin
      data_d.x = x_s - dx;
      data_d.y = y_s + dy;
      data_d.z = z_s - da;
    end else begin
      data_d.x = x_s + dx;
      data_d.y = y_s - dy;
      data_d.z = z_s + da;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    q_o       = data_q;
    q_o.valid = valid_q;
  end

endmodule

// ----- design/vector2_rotate.sv -----
// ----------------------------------------------------------------------------
// vector2_rotate: pipelined CORDIC rotation of a Q16.16 vector
// Reduces the angle modulo 2*pi, folds it into +-pi/2, applies the gain
// compensation and rotates through a chain of micro-rotation cells.
//
//   channel  | handshake         | fields
//   ---------+-------------------+-------------------------------
//   request  | start_i / busy_o  | x_in_i, y_in_i, angle_i
//   result   | done_o (strobe)   | x_out_o, y_out_o, clipped_o
//
// A request is taken every cycle; busy_o stays low.
// Pipeline stages in order: input register, 13 reduction cells,
// wrap, fold, gain multiply, one cell per micro-rotation and the output stage.
// Reset clears only the valid bits of the pipeline.
// done_o is high for one cycle per result; the receiver cannot stall.
// ----------------------------------------------------------------------------
module vector2_rotate
  import vr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic signed [CW-1:0] x_in_i,
  input  logic signed [CW-1:0] y_in_i,
  input  logic signed [CW-1:0] angle_i,
  output logic                 done_o,
  output logic signed [CW-1:0] x_out_o,
  output logic signed [CW-1:0] y_out_o,
  output logic                 clipped_o
);

  // Input stage: sign and magnitude of the angle in Q30.
  logic          in_valid_q;
  vr_mod_t       in_q;
  logic [CW:0]   ang_ext;
  logic [CW:0]   ang_abs;

  assign busy_o  = 1'b0;
  assign ang_ext = {angle_i[CW-1], angle_i};
  assign ang_abs = angle_i[CW-1] ? (~ang_ext + 1'b1) : ang_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q.valid <= 1'b0;
    in_q.neg   <= angle_i[CW-1];
    in_q.x     <= x_in_i;
    in_q.y     <= y_in_i;
    in_q.mag   <= {ang_abs[CW-1:0], 14'b0};
  end

  // Reduction chain, most significant quotient digit first.
  vr_mod_t mod_chain [MOD_STAGES+1];

  always_comb begin
    mod_chain[0]       = in_q;
    mod_chain[0].valid = in_valid_q;
  end

  for (genvar g = 0; g < MOD_STAGES; g++) begin : g_mod
    vr_mod_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .sub_i (vr_mod_sub(MOD_STAGES - 1 - g)),
      .d_i   (mod_chain[g]),
      .q_o   (mod_chain[g+1])
    );
  end

  // Wrap stage: apply the sign and bring the remainder into [-pi, pi).
  vr_mod_t              red;
  logic signed [RW-1:0] m_s;
  logic signed [RW-1:0] wrap_d;
  logic signed [RW-1:0] wrap_q;
  logic signed [CW-1:0] wrap_x_q;
  logic signed [CW-1:0] wrap_y_q;
  logic                 wrap_valid_q;

  assign red = mod_chain[MOD_STAGES];
  assign m_s = $signed(RW'(red.mag[32:0]));

  always_comb begin
    if (!red.neg) begin
      wrap_d = (m_s >= PI_R) ? (m_s - TWO_PI_R) : m_s;
    end else begin
      wrap_d = (m_s > PI_R) ? (TWO_PI_R - m_s) : -m_s;
    end
  end

  // Fold stage: keep the angle within +-pi/2, negating the vector by pi.
  logic signed [CW:0]   x_ext;
  logic signed [CW:0]   y_ext;
  logic signed [CW:0]   fold_x_d;
  logic signed [CW:0]   fold_y_d;
  logic signed [RW-1:0] fold_z_d;
  logic signed [CW:0]   fold_x_q;
  logic signed [CW:0]   fold_y_q;
  logic signed [ZW-1:0] fold_z_q;
  logic                 fold_valid_q;

  assign x_ext = (CW+1)'(wrap_x_q);
  assign y_ext = (CW+1)'(wrap_y_q);

  always_comb begin
    fold_x_d = x_ext;
    fold_y_d = y_ext;
    fold_z_d = wrap_q;
    if (wrap_q > HALF_PI_R) begin
      fold_z_d = wrap_q - PI_R;
      fold_x_d = -x_ext;
      fold_y_d = -y_ext;
    end else if (wrap_q < -HALF_PI_R) begin
      fold_z_d = wrap_q + PI_R;
      fold_x_d = -x_ext;
      fold_y_d = -y_ext;
    end
  end

  // Gain stage: scale by K in Q31 and floor-shift by 15 to Q16.32.
  logic signed [PW-1:0] prod_x;
  logic signed [PW-1:0] prod_y;
  logic                 gain_valid_q;
  vr_rot_t              gain_q;

  assign prod_x = PW'(fold_x_q) * GAIN_Q31;
  assign prod_y = PW'(fold_y_q) * GAIN_Q31;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_valid_q <= 1'b0;
      fold_valid_q <= 1'b0;
      gain_valid_q <= 1'b0;
    end else begin
      wrap_valid_q <= red.valid;
      fold_valid_q <= wrap_valid_q;
      gain_valid_q <= fold_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wrap_q       <= wrap_d;
    wrap_x_q     <= red.x;
    wrap_y_q     <= red.y;
    fold_x_q     <= fold_x_d;
    fold_y_q     <= fold_y_d;
    fold_z_q     <= ZW'(fold_z_d);
    gain_q.valid <= 1'b0;
    gain_q.x     <= prod_x[15 +: DW];
    gain_q.y     <= prod_y[15 +: DW];
    gain_q.z     <= fold_z_q;
  end

  // Micro-rotation chain.
  vr_rot_t rot_chain [VR_STEPS+1];

  always_comb begin
    rot_chain[0]       = gain_q;
    rot_chain[0].valid = gain_valid_q;
  end

  for (genvar g = 0; g < VR_STEPS; g++) begin : g_rot
    vr_rot_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .step_i(SW'(g)),
      .d_i   (rot_chain[g]),
      .q_o   (rot_chain[g+1])
    );
  end

  // Output stage: round half up to Q16.16 and saturate.
  vr_rot_t                 fin;
  logic signed [DW:0]      x_rnd;
  logic signed [DW:0]      y_rnd;
  logic signed [DW-16:0]   x_r;
  logic signed [DW-16:0]   y_r;
  logic signed [CW-1:0]    x_sat;
  logic signed [CW-1:0]    y_sat;
  logic                    x_clip;
  logic                    y_clip;
  logic                    done_q;
  logic signed [CW-1:0]    x_out_q;
  logic signed [CW-1:0]    y_out_q;
  logic                    clipped_q;

  localparam logic signed [DW-16:0] OUT_MAX = (DW-15)'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [DW-16:0] OUT_MIN = ~OUT_MAX;

  assign fin   = rot_chain[VR_STEPS];
  assign x_rnd = (DW+1)'(fin.x) + (DW+1)'(32'sd32768);
  assign y_rnd = (DW+1)'(fin.y) + (DW+1)'(32'sd32768);
  assign x_r   = x_rnd[DW:16];
  assign y_r   = y_rnd[DW:16];

  always_comb begin
    x_clip = 1'b0;
    y_clip = 1'b0;
    x_sat  = CW'(x_r);
    y_sat  = CW'(y_r);
    if (x_r > OUT_MAX) begin
      x_sat  = CW'(OUT_MAX);
      x_clip = 1'b1;
    end else if (x_r < OUT_MIN) begin
      x_sat  = CW'(OUT_MIN);
      x_clip = 1'b1;
    end
    if (y_r > OUT_MAX) begin
      y_sat  = CW'(OUT_MAX);
      y_clip = 1'b1;
    end else if (y_r < OUT_MIN) begin
      y_sat  = CW'(OUT_MIN);
      y_clip = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    x_out_q   <= x_sat;
    y_out_q   <= y_sat;
    clipped_q <= x_clip | y_clip;
  end

  assign done_o    = done_q;
  assign x_out_o   = x_out_q;
  assign y_out_o   = y_out_q;
  assign clipped_o = clipped_q;

endmodule
